// ----- sv/pme_pkg.sv -----
// ----------------------------------------------------------------------------
// pme_pkg
// Shared widths, operation codes and bundle types of the permutation mutation
// engine.
// ----------------------------------------------------------------------------
package pme_pkg;

   localparam int unsigned VAL_W      = 10;
   localparam int unsigned POS_W      = 10;
   localparam int unsigned OP_W       = 3;
   localparam int unsigned LEN_W      = 3;
   localparam int unsigned NUM_POS    = 5;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 16;

   typedef logic [VAL_W-1:0] val_type;
   typedef logic [POS_W-1:0] pos_type;
   typedef logic [OP_W-1:0]  op_type;
   typedef logic [LEN_W-1:0] len_type;

   localparam op_type OP_WRITE   = 3'd0;
   localparam op_type OP_READ    = 3'd1;
   localparam op_type OP_SWAP    = 3'd2;
   localparam op_type OP_INSERT  = 3'd3;
   localparam op_type OP_REVERSE = 3'd4;
   localparam op_type OP_ROTATE  = 3'd5;

   localparam len_type LEN_MIN = 3'd2;

   typedef struct packed {
      op_type  op;
      val_type value;
      pos_type pos_a;
      pos_type pos_b;
      pos_type pos_c;
      pos_type pos_d;
      pos_type pos_e;
      len_type cycle_len;
   } req_type;

   typedef struct packed {
      val_type read_value;
      logic    bad_request;
   } rsp_type;

   // One write port and two read ports of the element store.
   typedef struct packed {
      logic    we;
      pos_type waddr;
      val_type wdata;
      logic    rea;
      pos_type raddr_a;
      logic    reb;
      pos_type raddr_b;
   } mem_req_type;

endpackage

// ----- sv/permutation_mutation_engine.sv -----
// ----------------------------------------------------------------------------
// permutation_mutation_engine
// Each request is decoded in IDLE, walked through its read and write-back
// states and ends in RESP; refused or no-op requests go straight to RESP.
// The next request is taken once the response leaves the sequencer and it is
// back in IDLE; the store's single write port sets the pace.
// Reset clears all control state; the store's contents are undefined until
// written and need no clearing pass.
// ----------------------------------------------------------------------------
module permutation_mutation_engine #(
   parameter int unsigned TOUR_SIZE = 1024,
   parameter int unsigned MAX_CYCLE = 5
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata, low to high: value[9:0], pos_a[19:10], pos_b[29:20],
   // pos_c[39:30], pos_d[49:40], pos_e[59:50], cycle_len[62:60], zero [63].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // req_tuser: op[2:0].
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata, low to high: read_value[9:0], zero [15:10].
   output logic [15:0] rsp_tdata,
   // rsp_tuser: bad_request[0].
   output logic        rsp_tuser
);
   import pme_pkg::*;

   // Positions are ten bits wide, so no entry at or beyond 2**POS_W is reachable.
   localparam int unsigned STORE_DEPTH =
      (TOUR_SIZE < 2**POS_W) ? TOUR_SIZE : 2**POS_W;

   req_type     req;
   rsp_type     res;
   logic        res_valid;
   logic        res_ready;
   mem_req_type mem_req;
   val_type     rdata_a;
   val_type     rdata_b;

   // The output register lets the sequencer go back to idle once it hands a
   // response over; while the consumer holds that one off, the next one waits.
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   assign req.op        = req_tuser;
   assign req.value     = req_tdata[9:0];
   assign req.pos_a     = req_tdata[19:10];
   assign req.pos_b     = req_tdata[29:20];
   assign req.pos_c     = req_tdata[39:30];
   assign req.pos_d     = req_tdata[49:40];
   assign req.pos_e     = req_tdata[59:50];
   assign req.cycle_len = req_tdata[62:60];

   pme_seq #(
      .TOUR_SIZE (TOUR_SIZE),
      .MAX_CYCLE (MAX_CYCLE)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_req   (mem_req),
      .rdata_a   (rdata_a),
      .rdata_b   (rdata_b)
   );

   pme_store #(
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   // A new response is taken when the register is empty or drains this cycle.
   assign res_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (res_valid && res_ready) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.read_value};
   assign rsp_tuser  = out_ff.bad_request;

endmodule

// ----- sv/pme_store.sv -----
// ----------------------------------------------------------------------------
// pme_store
// Element store: one write port, two read ports with registered read data
// that holds its value while the port is not enabled.
// ----------------------------------------------------------------------------
module pme_store #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                 clock,
   input  pme_pkg::mem_req_type mem_req,
   output pme_pkg::val_type     rdata_a,
   output pme_pkg::val_type     rdata_b
);
   import pme_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   val_type mem [DEPTH];
   val_type rdata_a_ff;
   val_type rdata_b_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
      end
      if (mem_req.rea) begin
         rdata_a_ff <= mem[mem_req.raddr_a[AW-1:0]];
      end
      if (mem_req.reb) begin
         rdata_b_ff <= mem[mem_req.raddr_b[AW-1:0]];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ----- sv/pme_seq.sv -----
// ----------------------------------------------------------------------------
// pme_seq
// Operation sequencer: decodes a request, walks the store with read and
// write-back steps, and holds the response until the output stage takes it.
// ----------------------------------------------------------------------------
module pme_seq #(
   parameter int unsigned TOUR_SIZE = 1024,
   parameter int unsigned MAX_CYCLE = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pme_pkg::req_type     req,
   output logic                 res_valid,
   input  logic                 res_ready,
   output pme_pkg::rsp_type     res,
   output pme_pkg::mem_req_type mem_req,
   input  pme_pkg::val_type     rdata_a,
   input  pme_pkg::val_type     rdata_b
);
   import pme_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_WRITE     = 4'd1;
   localparam logic [3:0] S_READ      = 4'd2;
   localparam logic [3:0] S_READ_DATA = 4'd3;
   localparam logic [3:0] S_ROT_START = 4'd4;
   localparam logic [3:0] S_ROT_WRITE = 4'd5;
   localparam logic [3:0] S_ROT_READ  = 4'd6;
   localparam logic [3:0] S_ROT_LAST  = 4'd7;
   localparam logic [3:0] S_INS_FIRST = 4'd8;
   localparam logic [3:0] S_INS_RUN   = 4'd9;
   localparam logic [3:0] S_INS_LAST  = 4'd10;
   localparam logic [3:0] S_REV_READ  = 4'd11;
   localparam logic [3:0] S_REV_W1    = 4'd12;
   localparam logic [3:0] S_REV_W2    = 4'd13;
   localparam logic [3:0] S_RESP      = 4'd14;

   localparam logic [16:0] TOUR_LIM = 17'(TOUR_SIZE);
   localparam len_type     MAX_LEN  = LEN_W'(MAX_CYCLE);

   logic [3:0] state_ff, state_in;
   pos_type    pos_ff [MAX_CYCLE];
   pos_type    pos_in [MAX_CYCLE];
   val_type    value_ff, value_in;
   len_type    rem_ff, rem_in;
   pos_type    lo_ff, lo_in;
   pos_type    hi_ff, hi_in;
   logic       up_ff, up_in;
   rsp_type    res_ff, res_in;

   pos_type              pos_arr [NUM_POS];
   logic [NUM_POS-1:0]   pos_ok;
   pos_type              ins_next;
   pos_type              ins_next2;

   assign pos_arr[0] = req.pos_a;
   assign pos_arr[1] = req.pos_b;
   assign pos_arr[2] = req.pos_c;
   assign pos_arr[3] = req.pos_d;
   assign pos_arr[4] = req.pos_e;

   always_comb begin
      for (int i = 0; i < NUM_POS; i++) begin
         pos_ok[i] = (17'(pos_arr[i]) < TOUR_LIM);
      end
   end

   // Insert walks one position a step toward the target.
   assign ins_next  = up_ff ? lo_ff + 10'd1 : lo_ff - 10'd1;
   assign ins_next2 = up_ff ? ins_next + 10'd1 : ins_next - 10'd1;

   always_comb begin
      pos_type p_min;
      pos_type p_max;
      logic    rot_bad;
      state_in = state_ff;
      value_in = value_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      up_in    = up_ff;
      res_in   = res_ff;
      for (int i = 0; i < MAX_CYCLE; i++) begin
         pos_in[i] = pos_ff[i];
      end
      mem_req   = '0;
      req_ready = 1'b0;
      p_min     = (req.pos_a < req.pos_b) ? req.pos_a : req.pos_b;
      p_max     = (req.pos_a < req.pos_b) ? req.pos_b : req.pos_a;
      rot_bad   = (req.cycle_len < LEN_MIN) || (req.cycle_len > MAX_LEN);
      for (int i = 0; i < MAX_CYCLE; i++) begin
         if ((LEN_W'(i) < req.cycle_len) && !pos_ok[i]) begin
            rot_bad = 1'b1;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               for (int i = 0; i < MAX_CYCLE; i++) begin
                  pos_in[i] = pos_arr[i];
               end
               value_in = req.value;
               res_in   = '0;
               state_in = S_RESP;
               case (req.op)
                  OP_WRITE: begin
                     if (pos_ok[0]) state_in = S_WRITE;
                     else res_in.bad_request = 1'b1;
                  end
                  OP_READ: begin
                     if (pos_ok[0]) state_in = S_READ;
                     else res_in.bad_request = 1'b1;
                  end
                  OP_SWAP: begin
                     // A swap is a rotation over two positions.
                     rem_in = LEN_W'(1);
                     if (pos_ok[0] && pos_ok[1]) state_in = S_ROT_START;
                     else res_in.bad_request = 1'b1;
                  end
                  OP_INSERT: begin
                     lo_in = req.pos_a;
                     hi_in = req.pos_b;
                     up_in = req.pos_a < req.pos_b;
                     if (!(pos_ok[0] && pos_ok[1])) begin
                        res_in.bad_request = 1'b1;
                     end else if (req.pos_a != req.pos_b) begin
                        state_in = S_INS_FIRST;
                     end
                  end
                  OP_REVERSE: begin
                     lo_in = p_min;
                     hi_in = p_max - 10'd1;
                     if (!(pos_ok[0] && pos_ok[1])) begin
                        res_in.bad_request = 1'b1;
                     end else if ({1'b0, p_max} > ({1'b0, p_min} + 11'd1)) begin
                        state_in = S_REV_READ;
                     end
                  end
                  OP_ROTATE: begin
                     rem_in = req.cycle_len - LEN_W'(1);
                     if (rot_bad) res_in.bad_request = 1'b1;
                     else state_in = S_ROT_START;
                  end
                  default: begin
                     res_in.bad_request = 1'b1;
                  end
               endcase
            end
         end
         S_WRITE: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff[0];
            mem_req.wdata = value_ff;
            state_in      = S_RESP;
         end
         S_READ: begin
            mem_req.rea     = 1'b1;
            mem_req.raddr_a = pos_ff[0];
            state_in        = S_READ_DATA;
         end
         S_READ_DATA: begin
            res_in.read_value = rdata_a;
            state_in          = S_RESP;
         end
         S_ROT_START: begin
            // Port B keeps the first element until the final write.
            mem_req.rea     = 1'b1;
            mem_req.raddr_a = pos_ff[1];
            mem_req.reb     = 1'b1;
            mem_req.raddr_b = pos_ff[0];
            state_in        = S_ROT_WRITE;
         end
         S_ROT_WRITE: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff[0];
            mem_req.wdata = rdata_a;
            for (int i = 0; i < MAX_CYCLE - 1; i++) begin
               pos_in[i] = pos_ff[i+1];
            end
            rem_in   = rem_ff - LEN_W'(1);
            state_in = (rem_ff == LEN_W'(1)) ? S_ROT_LAST : S_ROT_READ;
         end
         S_ROT_READ: begin
            mem_req.rea     = 1'b1;
            mem_req.raddr_a = pos_ff[1];
            state_in        = S_ROT_WRITE;
         end
         S_ROT_LAST: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_ff[0];
            mem_req.wdata = rdata_b;
            state_in      = S_RESP;
         end
         S_INS_FIRST: begin
            mem_req.reb     = 1'b1;
            mem_req.raddr_b = lo_ff;
            mem_req.rea     = 1'b1;
            mem_req.raddr_a = ins_next;
            state_in        = S_INS_RUN;
         end
         S_INS_RUN: begin
            // Shift one element; the read runs two positions ahead of the write.
            mem_req.we    = 1'b1;
            mem_req.waddr = lo_ff;
            mem_req.wdata = rdata_a;
            lo_in         = ins_next;
            if (ins_next == hi_ff) begin
               state_in = S_INS_LAST;
            end else begin
               mem_req.rea     = 1'b1;
               mem_req.raddr_a = ins_next2;
            end
         end
         S_INS_LAST: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = hi_ff;
            mem_req.wdata = rdata_b;
            state_in      = S_RESP;
         end
         S_REV_READ: begin
            mem_req.rea     = 1'b1;
            mem_req.raddr_a = lo_ff;
            mem_req.reb     = 1'b1;
            mem_req.raddr_b = hi_ff;
            state_in        = S_REV_W1;
         end
         S_REV_W1: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = lo_ff;
            mem_req.wdata = rdata_b;
            state_in      = S_REV_W2;
         end
         S_REV_W2: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = hi_ff;
            mem_req.wdata = rdata_a;
            lo_in         = lo_ff + 10'd1;
            hi_in         = hi_ff - 10'd1;
            if ({1'b0, hi_ff} > ({1'b0, lo_ff} + 11'd2)) begin
               mem_req.rea     = 1'b1;
               mem_req.raddr_a = lo_ff + 10'd1;
               mem_req.reb     = 1'b1;
               mem_req.raddr_b = hi_ff - 10'd1;
               state_in        = S_REV_W1;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (res_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      for (int i = 0; i < MAX_CYCLE; i++) begin
         pos_ff[i] <= pos_in[i];
      end
      value_ff <= value_in;
      rem_ff   <= rem_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      up_ff    <= up_in;
      res_ff   <= res_in;
   end

   assign res_valid = (state_ff == S_RESP);
   assign res       = res_ff;

   a_port_a_overlap: assert property (@(posedge clock) disable iff (reset)
      mem_req.we && mem_req.rea |-> mem_req.waddr != mem_req.raddr_a)
      else $error("write and port A read hit the same entry");

   a_port_b_overlap: assert property (@(posedge clock) disable iff (reset)
      mem_req.we && mem_req.reb |-> mem_req.waddr != mem_req.raddr_b)
      else $error("write and port B read hit the same entry");

   a_quiet_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_RESP) |-> !mem_req.we)
      else $error("store written outside an operation");

   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.bad_request |-> res.read_value == '0)
      else $error("refused request carries read data");

   a_rot_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROT_WRITE |-> rem_ff != '0)
      else $error("rotation step count ran out");

endmodule

// ----- test/tb_permutation_mutation_engine.sv -----
// ----------------------------------------------------------------------------
// tb_permutation_mutation_engine
// Self-checking testbench for the permutation mutation engine. It loads two
// windows of the tour, one at the bottom and one at the top, and runs a
// directed set of edge cases. Random phases of writes, reads, swaps, moves,
// span reversals and cyclic rotations follow, with bad requests mixed in.
// Every position used lies in a loaded window. A shadow copy of the tour
// predicts each response, which is checked in request order.
// ----------------------------------------------------------------------------
module tb_permutation_mutation_engine;

   timeunit 1ns;
   timeprecision 1ps;

   import pme_pkg::*;

   localparam int TOUR           = 1024;
   localparam int CYCLE_LIMIT    = 5;
   localparam int LOAD_SPAN      = 64;
   localparam int DIRECTED_COUNT = 26;
   localparam int PHASE_GAPS     = 100;
   localparam int PHASE_FLAT     = 80;
   localparam int PHASE_LAST     = 120;
   // The long stall lands 40 requests into the last random phase.
   localparam int HOLDOFF_AT     = 2 * LOAD_SPAN + DIRECTED_COUNT + PHASE_GAPS +
                                   PHASE_FLAT + 40;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int GAP_PERCENT    = 35;
   localparam int MAX_PRINTED    = 40;

   // Opcodes that the engine does not implement; both must be refused.
   localparam op_type  OP_SPARE_LO = 3'd6;
   localparam op_type  OP_SPARE_HI = 3'd7;
   localparam len_type LEN_MAX     = 3'd5;
   localparam pos_type POS_LAST    = 10'd1023;
   localparam pos_type LOW_LAST    = pos_type'(LOAD_SPAN - 1);
   localparam pos_type HIGH_FIRST  = pos_type'(TOUR - LOAD_SPAN);
   localparam val_type VAL_ALL     = 10'd1023;

   // Clock and reset. Reset is held from the start until the stimulus releases it.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Request channel.
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // req_tdata, low to high: value, pos_a, pos_b, pos_c, pos_d, pos_e,
   // cycle_len, one zero pad bit.
   logic [63:0] req_tdata = '0;
   // req_tuser: op.
   logic [2:0]  req_tuser = '0;

   // Response channel.
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // rsp_tdata, low to high: read_value, six zero pad bits.
   logic [15:0] rsp_tdata;
   // rsp_tuser: bad_request.
   logic        rsp_tuser;

   permutation_mutation_engine #(
      .TOUR_SIZE (TOUR),
      .MAX_CYCLE (CYCLE_LIMIT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Requests waiting to be offered, and responses that are owed by the engine
   // in the order their requests were accepted.
   req_type pending_requests [$];
   rsp_type owed_responses [$];

   // The request currently on the bus, kept whole so the predictor need not
   // unpack the bus.
   req_type req_cur;

   // The driver counts requests it has put on the bus and the monitor counts
   // the ones the engine took. While they differ, the bus holds its request.
   int req_issue_count  = 0;
   int req_accept_count = 0;

   // Random gaps on both sides are switched off for one whole phase. The hold
   // flag stalls the response side for a long stretch.
   bit traffic_gaps = 1'b1;
   bit rsp_hold     = 1'b0;

   int mismatch_count = 0;

   // Shadow copy of the tour. Both windows are written by the load phase
   // before anything else, and no request touches an entry outside them, so
   // no response ever depends on an unwritten entry.
   val_type tour [TOUR];

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED) begin
         $display("MISMATCH @%0t: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // Applies one request to the shadow tour and returns the response that the
   // engine owes for it. Refused requests leave the tour untouched.
   function automatic rsp_type apply_mutation(input req_type r);
      rsp_type res;
      val_type held;
      int      lo;
      int      hi;
      int      i;
      int      idx [CYCLE_LIMIT];

      res = '0;
      case (r.op)
         OP_WRITE: begin
            tour[r.pos_a] = r.value;
         end
         OP_READ: begin
            res.read_value = tour[r.pos_a];
         end
         OP_SWAP: begin
            held         = tour[r.pos_a];
            tour[r.pos_a] = tour[r.pos_b];
            tour[r.pos_b] = held;
         end
         OP_INSERT: begin
            // The moved element lands at pos_b; everything between shifts one
            // place back toward pos_a.
            held = tour[r.pos_a];
            if (r.pos_a < r.pos_b) begin
               for (i = r.pos_a; i < r.pos_b; i++) tour[i] = tour[i + 1];
            end else begin
               for (i = r.pos_a; i > r.pos_b; i--) tour[i] = tour[i - 1];
            end
            tour[r.pos_b] = held;
         end
         OP_REVERSE: begin
            // Half-open span from the lower to the higher position.
            lo = (r.pos_a < r.pos_b) ? r.pos_a : r.pos_b;
            hi = (r.pos_a < r.pos_b) ? r.pos_b : r.pos_a;
            while (hi > lo + 1) begin
               held         = tour[lo];
               tour[lo]     = tour[hi - 1];
               tour[hi - 1] = held;
               lo++;
               hi--;
            end
         end
         OP_ROTATE: begin
            if (r.cycle_len < LEN_MIN || r.cycle_len > LEN_MAX) begin
               res.bad_request = 1'b1;
            end else begin
               // Repeated positions are handled by the same in-order rule.
               idx[0] = r.pos_a;
               idx[1] = r.pos_b;
               idx[2] = r.pos_c;
               idx[3] = r.pos_d;
               idx[4] = r.pos_e;
               held   = tour[idx[0]];
               for (i = 0; i + 1 < r.cycle_len; i++) tour[idx[i]] = tour[idx[i + 1]];
               tour[idx[r.cycle_len - 1]] = held;
            end
         end
         default: begin
            res.bad_request = 1'b1;
         end
      endcase
      return res;
   endfunction

   // Request driver. Inputs change on the falling edge so that the engine
   // samples stable values on the rising edge.
   always @(negedge clock) begin : request_driver
      req_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_accept_count == req_issue_count) begin
         // The bus is free: either nothing was offered or the last request was
         // taken on the rising edge just past.
         if (pending_requests.size() != 0 &&
             !(traffic_gaps && $urandom_range(0, 99) < GAP_PERCENT)) begin
            r = pending_requests.pop_front();
            req_cur    <= r;
            req_tuser  <= r.op;
            req_tdata  <= {1'b0, r.cycle_len, r.pos_e, r.pos_d, r.pos_c, r.pos_b,
                           r.pos_a, r.value};
            req_tvalid <= 1'b1;
            req_issue_count++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response side ready, with random gaps and the long hold-off.
   always @(negedge clock) begin : response_ready
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !rsp_hold &&
                       !(traffic_gaps && $urandom_range(0, 99) < GAP_PERCENT);
      end
   end

   // Monitor. The response is checked before the request of the same edge is
   // predicted, since a response can never belong to a request taken at the
   // same edge.
   always @(posedge clock) begin : channel_monitor
      rsp_type owed;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_responses.size() == 0) begin
               report_mismatch($sformatf("response with no request outstanding, data %h",
                                         rsp_tdata));
            end else begin
               owed = owed_responses.pop_front();
               if (rsp_tdata[9:0] !== owed.read_value) begin
                  report_mismatch($sformatf("read_value %h, want %h",
                                            rsp_tdata[9:0], owed.read_value));
               end
               if (rsp_tuser !== owed.bad_request) begin
                  report_mismatch($sformatf("bad_request %b, want %b",
                                            rsp_tuser, owed.bad_request));
               end
               if (rsp_tdata[15:10] !== 6'd0) begin
                  report_mismatch($sformatf("pad bits of rsp_tdata %h not zero",
                                            rsp_tdata[15:10]));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            owed_responses.push_back(apply_mutation(req_cur));
            req_accept_count++;
         end
      end
   end

   // Long receiver stall partway into the last random phase. The sender keeps
   // offering, so the engine fills and drops req_tready.
   initial begin : response_holdoff
      wait (req_accept_count >= HOLDOFF_AT);
      @(negedge clock) rsp_hold <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic push_request(input op_type op, input val_type value,
                               input pos_type pos_a, input pos_type pos_b,
                               input pos_type pos_c = '0, input pos_type pos_d = '0,
                               input pos_type pos_e = '0, input len_type cycle_len = '0);
      req_type r;
      r.op        = op;
      r.value     = value;
      r.pos_a     = pos_a;
      r.pos_b     = pos_b;
      r.pos_c     = pos_c;
      r.pos_d     = pos_d;
      r.pos_e     = pos_e;
      r.cycle_len = cycle_len;
      pending_requests.push_back(r);
   endtask

   // The sender pauses here until every request went out and every owed
   // response came back.
   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_issue_count != req_accept_count ||
             owed_responses.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // A random position inside one of the two loaded windows.
   function automatic pos_type pick_pos();
      if ($urandom_range(0, 1) != 0) begin
         return pos_type'($urandom_range(0, LOAD_SPAN - 1));
      end
      return pos_type'($urandom_range(TOUR - LOAD_SPAN, TOUR - 1));
   endfunction

   // Random requests. Moves and reversals stay inside the window of pos_a and
   // mostly stay short, since their cost grows with the distance; one in ten
   // spans anything up to the whole window.
   task automatic run_random(input int count);
      op_type  op;
      len_type cycle_len;
      pos_type pos_a;
      pos_type pos_b;
      int      pick;
      int      near;
      int      win_lo;
      repeat (count) begin
         pick      = int'($urandom_range(0, 99));
         pos_a     = pick_pos();
         pos_b     = pick_pos();
         cycle_len = len_type'($urandom_range(0, 7));
         if (pick < 12) op = OP_WRITE;
         else if (pick < 30) op = OP_READ;
         else if (pick < 45) op = OP_SWAP;
         else if (pick < 62) op = OP_INSERT;
         else if (pick < 79) op = OP_REVERSE;
         else if (pick < 95) op = OP_ROTATE;
         else op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
         if (op == OP_INSERT || op == OP_REVERSE) begin
            win_lo = (int'(pos_a) < LOAD_SPAN) ? 0 : TOUR - LOAD_SPAN;
            if ($urandom_range(0, 9) != 0) begin
               near = int'(pos_a) + int'($urandom_range(0, 24)) - 12;
               if (near < win_lo) near = win_lo;
               if (near > win_lo + LOAD_SPAN - 1) near = win_lo + LOAD_SPAN - 1;
            end else begin
               near = win_lo + int'($urandom_range(0, LOAD_SPAN - 1));
            end
            pos_b = pos_type'(near);
         end
         if (op == OP_ROTATE) begin
            // Mostly legal lengths; the rest are 0, 1, 6 or 7.
            if ($urandom_range(0, 99) < 85) begin
               cycle_len = len_type'($urandom_range(LEN_MIN, LEN_MAX));
            end else begin
               pick      = int'($urandom_range(0, 3));
               cycle_len = len_type'((pick < 2) ? pick : pick + 4);
            end
         end
         push_request(op, val_type'($urandom_range(0, TOUR - 1)), pos_a, pos_b,
                      pick_pos(), pick_pos(), pick_pos(), cycle_len);
      end
   endtask

   // Stimulus and end of run.
   initial begin : stimulus
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Load both windows of the tour with random values.
      for (int i = 0; i < LOAD_SPAN; i++) begin
         push_request(OP_WRITE, val_type'($urandom_range(0, TOUR - 1)), pos_type'(i),
                      pos_type'($urandom_range(0, TOUR - 1)));
         push_request(OP_WRITE, val_type'($urandom_range(0, TOUR - 1)),
                      pos_type'(TOUR - LOAD_SPAN + i),
                      pos_type'($urandom_range(0, TOUR - 1)));
      end
      wait_until_drained();

      // Directed edge cases.
      push_request(OP_WRITE, '0, '0, POS_LAST);
      push_request(OP_WRITE, VAL_ALL, POS_LAST, '0);
      push_request(OP_READ, '0, '0, '0);
      push_request(OP_READ, VAL_ALL, POS_LAST, POS_LAST);
      push_request(OP_SWAP, '0, '0, POS_LAST);
      push_request(OP_READ, '0, '0, '0);
      push_request(OP_SWAP, '0, 10'd7, 10'd7);
      // Moves over a whole window in both directions, a no-op and a neighbor.
      push_request(OP_INSERT, '0, '0, LOW_LAST);
      push_request(OP_INSERT, '0, POS_LAST, HIGH_FIRST);
      push_request(OP_INSERT, '0, 10'd30, 10'd30);
      push_request(OP_INSERT, '0, 10'd5, 10'd6);
      // Reversal of nearly the whole upper window, a one-element span and an
      // empty span.
      push_request(OP_REVERSE, '0, POS_LAST, HIGH_FIRST);
      push_request(OP_REVERSE, '0, 10'd10, 10'd11);
      push_request(OP_REVERSE, '0, 10'd20, 10'd20);
      // Rotations of every legal length, then one with repeated positions.
      push_request(OP_ROTATE, '0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, LEN_MIN);
      push_request(OP_ROTATE, '0, 10'd60, 10'd50, 10'd990, 10'd4, 10'd5, 3'd3);
      push_request(OP_ROTATE, '0, POS_LAST, '0, 10'd1000, 10'd40, 10'd5, 3'd4);
      push_request(OP_ROTATE, '0, 10'd9, 10'd8, 10'd7, 10'd6, POS_LAST, LEN_MAX);
      push_request(OP_ROTATE, '0, 10'd3, 10'd4, 10'd3, 10'd4, 10'd3, LEN_MAX);
      // Refused requests: illegal cycle lengths and the spare opcodes, then a read.
      push_request(OP_ROTATE, VAL_ALL, '0, POS_LAST, '0, POS_LAST, '0, 3'd0);
      push_request(OP_ROTATE, VAL_ALL, '0, POS_LAST, '0, POS_LAST, '0, 3'd1);
      push_request(OP_ROTATE, VAL_ALL, '0, POS_LAST, '0, POS_LAST, '0, 3'd6);
      push_request(OP_ROTATE, VAL_ALL, POS_LAST, '0, POS_LAST, '0, POS_LAST, 3'd7);
      push_request(OP_SPARE_LO, VAL_ALL, '0, POS_LAST, POS_LAST, POS_LAST, POS_LAST, 3'd7);
      push_request(OP_SPARE_HI, VAL_ALL, POS_LAST, '0, '0, '0, '0, LEN_MIN);
      push_request(OP_READ, '0, POS_LAST, '0);
      wait_until_drained();

      // Random phases: with gaps, then a stretch with none, then gaps again
      // with the long receiver stall landing in the middle.
      run_random(PHASE_GAPS);
      wait_until_drained();
      @(negedge clock) traffic_gaps = 1'b0;
      run_random(PHASE_FLAT);
      wait_until_drained();
      @(negedge clock) traffic_gaps = 1'b1;
      run_random(PHASE_LAST);
      wait_until_drained();

      // Allow for any stray late response before the verdict.
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #50ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
